// ----- rtl/i2csrf_pkg.sv -----
`default_nettype none

package i2csrf_pkg;

  // register file geometry
  localparam int NUM_REGS = 16;
  localparam int PTR_W    = 4;

  // event codes
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_SHIFT = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // configuration register indexes
  localparam int         CFG_IDX_W      = 1;
  localparam logic [0:0] CFG_OWN_ADDR   = 1'b0;
  localparam logic [0:0] CFG_WRITE_MASK = 1'b1;

  localparam logic [6:0] OWN_ADDR_RST   = 7'h00;
  localparam logic [7:0] WRITE_MASK_RST = 8'hFF;

  // shift register loads
  localparam logic [7:0] LOAD_NAK = 8'h80;
  localparam logic [7:0] LOAD_ACK = 8'h00;

  typedef enum logic [4:0] {
    ST_ADDR  = 5'b00001,
    ST_PTR   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_IDLE  = 5'b10000
  } bus_state_t;

  typedef struct packed {
    logic [7:0] shift_load;
    logic       sda_drive;
    logic       ack_phase_next;
    logic       write_strobe;
    logic [3:0] write_index;
    logic [7:0] write_value;
    logic [7:0] update_count;
    logic       busy_res;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

endpackage

`default_nettype wire

// ----- rtl/i2csrf_regs.sv -----
`default_nettype none

module i2csrf_regs
  import i2csrf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire wr_t              wr,
  input  wire logic [PTR_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr.en) begin
      regs_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = regs_r[rd_addr];

endmodule

`default_nettype wire

// ----- rtl/i2csrf_ctrl.sv -----
`default_nettype none

module i2csrf_ctrl
  import i2csrf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [1:0]       kind,
  input  wire logic [7:0]       shift_byte,
  input  wire logic [6:0]       own_address,
  input  wire logic [7:0]       write_mask,
  input  wire logic [7:0]       rd_data,
  output logic      [PTR_W-1:0] rd_addr,
  output wr_t                   wr,
  output res_t                  res
);

  bus_state_t       state_r, state_nxt;
  logic             ack_r, ack_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt, ptr_inc;
  logic [7:0]       wcnt_r, wcnt_nxt;
  logic [7:0]       merged;
  logic [6:0]       addr;

  assign addr    = shift_byte[7:1];
  assign ptr_inc = (ptr_r == PTR_W'(NUM_REGS - 1)) ? '0 : ptr_r + 1'b1;
  assign merged  = (rd_data & ~write_mask) | (shift_byte & write_mask);
  assign rd_addr = ptr_r;

  always_comb begin
    state_nxt = state_r;
    ack_nxt   = ack_r;
    ptr_nxt   = ptr_r;
    wcnt_nxt  = wcnt_r;
    res       = '0;

    case (kind)
      KIND_START: begin
        state_nxt = ST_ADDR;
        ack_nxt   = 1'b0;
      end
      KIND_SHIFT: begin
        if (!ack_r) begin
          // byte phase: answer with an ack bit next
          res.sda_drive      = 1'b1;
          res.ack_phase_next = 1'b1;
          ack_nxt            = 1'b1;
          unique case (state_r)
            ST_ADDR: begin
              if (addr != 7'd0 && addr != own_address) begin
                state_nxt      = ST_IDLE;
                res.shift_load = LOAD_NAK;
              end else begin
                if (shift_byte[0]) begin
                  state_nxt = ST_READ;
                end else begin
                  ptr_nxt   = '0;
                  state_nxt = ST_PTR;
                  wcnt_nxt  = 8'd1;
                end
                res.shift_load = LOAD_ACK;
              end
            end
            ST_PTR: begin
              if ({1'b0, shift_byte} >= 9'(NUM_REGS)) begin
                state_nxt      = ST_IDLE;
                res.shift_load = LOAD_NAK;
              end else begin
                ptr_nxt        = shift_byte[PTR_W-1:0];
                state_nxt      = ST_WRITE;
                res.shift_load = LOAD_ACK;
              end
            end
            ST_READ: begin
              res.shift_load = '0;
              res.sda_drive  = 1'b0;
            end
            ST_WRITE: begin
              if (write_mask != 8'd0) begin
                res.write_strobe = 1'b1;
                res.write_index  = 4'(ptr_r);
                res.write_value  = merged;
              end
              wcnt_nxt       = wcnt_r + 8'd1;
              ptr_nxt        = ptr_inc;
              res.shift_load = LOAD_ACK;
            end
            default: begin
              res.shift_load = LOAD_NAK;
            end
          endcase
        end else begin
          // ack phase: master ack continues a read
          ack_nxt = 1'b0;
          if (state_r == ST_READ) begin
            if (shift_byte != 8'd0) begin
              ptr_nxt   = '0;
              state_nxt = ST_IDLE;
            end else begin
              res.sda_drive  = 1'b1;
              res.shift_load = rd_data;
              ptr_nxt        = ptr_inc;
            end
          end
        end
      end
      KIND_STOP: begin
        if (state_r == ST_WRITE && wcnt_r != 8'd0) begin
          state_nxt        = ST_IDLE;
          res.update_count = wcnt_r;
          wcnt_nxt         = '0;
        end
      end
      default: begin
      end
    endcase

    res.busy_res = (state_nxt == ST_PTR) || (state_nxt == ST_READ) || (state_nxt == ST_WRITE);
  end

  assign wr.en   = fire && res.write_strobe;
  assign wr.idx  = ptr_r;
  assign wr.data = merged;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ADDR;
      ack_r   <= 1'b0;
      ptr_r   <= '0;
      wcnt_r  <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      ack_r   <= ack_nxt;
      ptr_r   <= ptr_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_slave_register_file.sv -----
`default_nettype none

// Byte-level I2C slave in front of a 16 x 8-bit register file. Each input
// transaction is one bus event from the shift-register front end: a start
// condition, the end of a shift phase, or a stop condition. The block keeps
// track of byte and acknowledge phases itself, matches the 7-bit own address
// (the general call, address 0, is also answered), takes a register pointer
// (pointers beyond the file are refused with a nak), writes bytes under the
// global write mask and returns read data while the master acknowledges; the
// pointer wraps at the end of the file. Every event yields exactly one result
// transaction. The input register captures the event, then the control logic
// and register-file read feed the result register. A new event can be taken
// every cycle while the result side does not stall; the result register holds
// a finished result while the next event is already being captured.
// Configuration (index 0 own address, index 1 write mask) is always ready and
// must only be written while no event is in flight. The register file clears
// to zero on reset.

module i2c_slave_register_file
  import i2csrf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_kind,
  input  wire logic [7:0]           in_shift_byte,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [7:0]           out_shift_load,
  output logic                      out_sda_drive,
  output logic                      out_ack_phase_next,
  output logic                      out_write_strobe,
  output logic      [3:0]           out_write_index,
  output logic      [7:0]           out_write_value,
  output logic      [7:0]           out_update_count,
  output logic                      out_busy_res,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // config registers
  logic [6:0] own_addr_r;
  logic [7:0] wmask_r;

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_byte_r;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r;
  res_t       res;

  logic             in_acc;
  logic             move;
  wr_t              wr;
  logic [PTR_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RST;
      wmask_r    <= WRITE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ADDR:   own_addr_r <= cfg_data[6:0];
        CFG_WRITE_MASK: wmask_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // handshake: the event in the input register is processed when the
  // result register is empty or being drained this cycle
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_shift_byte;
    end
    if (move) begin
      res_r <= res;
    end
  end

  i2csrf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (move),
    .kind        (s1_kind_r),
    .shift_byte  (s1_byte_r),
    .own_address (own_addr_r),
    .write_mask  (wmask_r),
    .rd_data     (rd_data),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .res         (res)
  );

  i2csrf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid          = out_valid_r;
  assign out_shift_load     = res_r.shift_load;
  assign out_sda_drive      = res_r.sda_drive;
  assign out_ack_phase_next = res_r.ack_phase_next;
  assign out_write_strobe   = res_r.write_strobe;
  assign out_write_index    = res_r.write_index;
  assign out_write_value    = res_r.write_value;
  assign out_update_count   = res_r.update_count;
  assign out_busy_res       = res_r.busy_res;

  // a register write only happens in a byte phase, which the slave acks
  a_strobe_in_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_strobe |-> out_ack_phase_next && out_sda_drive
      && out_shift_load == LOAD_ACK)
    else $error("write strobe outside an acked byte phase");

  // a reported update count ends the write transfer
  a_update_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_update_count != 8'd0 |-> !out_busy_res && !out_ack_phase_next)
    else $error("update count while still busy");

  // stall only while an event is waiting in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with nothing pending");

  // an event processed into a held result register would overwrite it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> !$past(move))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  import i2csrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kind 3 is not a bus event; the slave must leave its state alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Master acknowledge as seen in the shift byte; any nonzero byte is a not-acknowledge.
  localparam logic [7:0] MASTER_ACK = 8'h00;

  // Six traffic phases, each under its own address/mask setting.
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_EVENTS = 175;

  // Scoreboard: tracks the slave's bus state and register file, and holds
  // the result transaction each accepted bus event should produce.
  class i2c_event_scoreboard;
    logic [6:0]  addr_cfg;
    logic [7:0]  mask_cfg;
    bus_state_t  bus;
    bit          acking;
    int unsigned ptr;
    logic [7:0]  wr_count;
    logic [7:0]  regs [NUM_REGS];
    res_t        pending_results [$];
    int          errors;

    function new();
      addr_cfg = OWN_ADDR_RST;
      mask_cfg = WRITE_MASK_RST;
      bus      = ST_ADDR;
      acking   = 1'b0;
      ptr      = 0;
      wr_count = 8'h00;
      errors   = 0;
      foreach (regs[i]) regs[i] = 8'h00;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_OWN_ADDR:   addr_cfg = data[6:0];
        CFG_WRITE_MASK: mask_cfg = data;
        default: ;
      endcase
    endfunction

    // Advance the slave by one bus event and queue the result it must give.
    function void note_event(logic [1:0] kind, logic [7:0] b);
      res_t r;
      r = '0;
      case (kind)
        KIND_START: begin
          bus    = ST_ADDR;
          acking = 1'b0;
        end
        KIND_SHIFT: begin
          if (!acking) begin
            // end of an eight-bit byte phase
            r.sda_drive = 1'b1;
            case (bus)
              ST_ADDR: begin
                if (b[7:1] != 7'h00 && b[7:1] != addr_cfg) begin
                  bus          = ST_IDLE;
                  r.shift_load = LOAD_NAK;
                end else begin
                  if (b[0]) begin
                    bus = ST_READ;
                  end else begin
                    ptr      = 0;
                    bus      = ST_PTR;
                    wr_count = 8'd1;
                  end
                  r.shift_load = LOAD_ACK;
                end
              end
              ST_PTR: begin
                if (b > NUM_REGS - 1) begin
                  bus          = ST_IDLE;
                  r.shift_load = LOAD_NAK;
                end else begin
                  ptr          = b;
                  bus          = ST_WRITE;
                  r.shift_load = LOAD_ACK;
                end
              end
              ST_READ: begin
                // slave just shifted data out; master owns the ack bit
                r.sda_drive = 1'b0;
              end
              ST_WRITE: begin
                // zero mask: byte is still acked and counted, nothing stored
                if (mask_cfg != 8'h00) begin
                  regs[ptr]       = (regs[ptr] & ~mask_cfg) | (b & mask_cfg);
                  r.write_strobe  = 1'b1;
                  r.write_index   = 4'(ptr);
                  r.write_value   = regs[ptr];
                end
                wr_count     = wr_count + 8'd1;
                ptr          = ptr + 1;
                r.shift_load = LOAD_ACK;
              end
              default: r.shift_load = LOAD_NAK;
            endcase
            r.ack_phase_next = 1'b1;
            acking           = 1'b1;
          end else begin
            // end of the one-bit acknowledge phase
            if (bus == ST_READ) begin
              if (b != MASTER_ACK) begin
                ptr = 0;
                bus = ST_IDLE;
              end else begin
                r.sda_drive  = 1'b1;
                r.shift_load = regs[ptr];
                ptr          = ptr + 1;
              end
            end
            acking = 1'b0;
          end
          if (ptr > NUM_REGS - 1) ptr = 0;
        end
        KIND_STOP: begin
          // a wrapped count looks like no write at all
          if (bus == ST_WRITE && wr_count != 8'h00) begin
            bus            = ST_IDLE;
            r.update_count = wr_count;
            wr_count       = 8'h00;
          end
        end
        default: ;
      endcase
      r.busy_res = (bus == ST_PTR || bus == ST_READ || bus == ST_WRITE);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report("result transaction with no bus event outstanding");
        return;
      end
      want = pending_results.pop_front();
      cmp_field("shift_load",     got.shift_load,         want.shift_load);
      cmp_field("sda_drive",      8'(got.sda_drive),      8'(want.sda_drive));
      cmp_field("ack_phase_next", 8'(got.ack_phase_next), 8'(want.ack_phase_next));
      cmp_field("write_strobe",   8'(got.write_strobe),   8'(want.write_strobe));
      cmp_field("write_index",    8'(got.write_index),    8'(want.write_index));
      cmp_field("write_value",    got.write_value,        want.write_value);
      cmp_field("update_count",   got.update_count,       want.update_count);
      cmp_field("busy_res",       8'(got.busy_res),       8'(want.busy_res));
    endtask
  endclass

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind       = KIND_START;
  logic [7:0]           in_shift_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [7:0]           out_shift_load;
  logic                 out_sda_drive;
  logic                 out_ack_phase_next;
  logic                 out_write_strobe;
  logic [3:0]           out_write_index;
  logic [7:0]           out_write_value;
  logic [7:0]           out_update_count;
  logic                 out_busy_res;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_OWN_ADDR;
  logic [7:0]           cfg_data      = 8'h00;

  i2c_event_scoreboard sb;
  int tx_gap_max   = 3;   // longest pause before an event, in cycles
  int rx_stall_max = 3;   // longest stall before taking a result
  int events_sent  = 0;

  always #1 clk = ~clk;

  i2c_slave_register_file dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_shift_byte      (in_shift_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shift_load     (out_shift_load),
    .out_sda_drive      (out_sda_drive),
    .out_ack_phase_next (out_ack_phase_next),
    .out_write_strobe   (out_write_strobe),
    .out_write_index    (out_write_index),
    .out_write_value    (out_write_value),
    .out_update_count   (out_update_count),
    .out_busy_res       (out_busy_res),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Send one bus event. An optional pause drops valid first; with no pause,
  // valid stays high straight from the previous transaction.
  task automatic put_item(logic [1:0] kind, logic [7:0] data);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_shift_byte <= data;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_event(kind, data);
    events_sent++;
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_results.size() != 0);
  endtask

  // Both registers are written back to back; valid stays high between them.
  task automatic program_slave(logic [7:0] addr_word, logic [7:0] mask_word);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OWN_ADDR;
    cfg_data  <= addr_word;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(CFG_OWN_ADDR, addr_word);
    cfg_index <= CFG_WRITE_MASK;
    cfg_data  <= mask_word;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(CFG_WRITE_MASK, mask_word);
    cfg_valid <= 1'b0;
  endtask

  // Mostly our own address, sometimes the general call, sometimes a stranger.
  function automatic logic [6:0] pick_addr();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return sb.addr_cfg;
    if (roll < 85) return 7'h00;
    return 7'($urandom_range(127));
  endfunction

  // Mostly valid pointers; the rest includes the first one past the file.
  function automatic logic [7:0] pick_ptr();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return 8'($urandom_range(NUM_REGS - 1));
    if (roll < 90) return 8'(NUM_REGS);
    return 8'($urandom_range(255));
  endfunction

  // Ack bit after a byte the master wrote; the slave ignores it.
  function automatic logic [7:0] any_ack();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : MASTER_ACK;
  endfunction

  // START, address+W, pointer, n data bytes, optional STOP.
  task automatic write_xfer(logic [6:0] addr, logic [7:0] p, int n, bit with_stop);
    put_item(KIND_START, 8'($urandom_range(255)));
    put_item(KIND_SHIFT, {addr, 1'b0});
    put_item(KIND_SHIFT, any_ack());
    put_item(KIND_SHIFT, p);
    put_item(KIND_SHIFT, any_ack());
    repeat (n) begin
      put_item(KIND_SHIFT, 8'($urandom_range(255)));
      put_item(KIND_SHIFT, any_ack());
    end
    if (with_stop) put_item(KIND_STOP, 8'($urandom_range(255)));
  endtask

  // START, address+R, then n bytes read; the master acks all but the last,
  // which it naks with some nonzero shift byte, and then STOP.
  task automatic read_xfer(logic [6:0] addr, int n);
    put_item(KIND_START, 8'($urandom_range(255)));
    put_item(KIND_SHIFT, {addr, 1'b1});
    put_item(KIND_SHIFT, MASTER_ACK);
    repeat (n - 1) begin
      put_item(KIND_SHIFT, 8'($urandom_range(255)));
      put_item(KIND_SHIFT, MASTER_ACK);
    end
    put_item(KIND_SHIFT, 8'($urandom_range(255)));
    put_item(KIND_SHIFT, 8'($urandom_range(255, 1)));
    put_item(KIND_STOP, 8'($urandom_range(255)));
  endtask

  // Mix of well-formed transfers and raw noise events.
  task automatic random_traffic(int n);
    int stop_at;
    int pick;
    stop_at = events_sent + n;
    while (events_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        write_xfer(pick_addr(), pick_ptr(), $urandom_range(4), $urandom_range(9) != 0);
      end else if (pick < 60) begin
        read_xfer(pick_addr(), $urandom_range(4, 1));
      end else if (pick < 85) begin
        // set the pointer, then a repeated start into a read
        write_xfer(pick_addr(), pick_ptr(), 0, 1'b0);
        read_xfer(pick_addr(), $urandom_range(4, 1));
      end else begin
        repeat ($urandom_range(6, 1))
          put_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Result side: random stall ahead of each result, then take it and check.
  initial begin
    int   hold;
    res_t got;
    wait (rst_n === 1'b1);
    forever begin
      hold = (rx_stall_max == 0) ? 0 : $urandom_range(rx_stall_max);
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{shift_load:     out_shift_load,
              sda_drive:      out_sda_drive,
              ack_phase_next: out_ack_phase_next,
              write_strobe:   out_write_strobe,
              write_index:    out_write_index,
              write_value:    out_write_value,
              update_count:   out_update_count,
              busy_res:       out_busy_res};
      sb.check_result(got);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [6:0] addr;
    logic [7:0] mask;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Own address 0x55 (bit 7 of the data word is ignored).
    program_slave(8'hD5, 8'hFF);
    put_item(KIND_UNUSED, 8'hFF);         // not an event: no state change
    put_item(KIND_STOP, 8'h00);           // stop with no write pending
    // write to the last register, pointer wraps, second byte lands in reg 0
    put_item(KIND_START, 8'h00);
    put_item(KIND_SHIFT, {7'h55, 1'b0});
    put_item(KIND_SHIFT, 8'hFF);
    put_item(KIND_SHIFT, 8'(NUM_REGS - 1));
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_SHIFT, 8'hFF);
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_SHIFT, 8'h00);
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_STOP, 8'hFF);           // update count 3
    // read one byte, master releases with a nak
    put_item(KIND_START, 8'h00);
    put_item(KIND_SHIFT, {7'h55, 1'b1});
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_SHIFT, 8'hA5);
    put_item(KIND_SHIFT, 8'h01);
    put_item(KIND_STOP, 8'h00);           // ignored outside a write
    // foreign address: nak, then idle naks every byte
    put_item(KIND_START, 8'h00);
    put_item(KIND_SHIFT, {7'h2A, 1'b0});
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_SHIFT, 8'h03);
    // general call with a pointer far out of range
    put_item(KIND_START, 8'h00);
    put_item(KIND_SHIFT, 8'h00);
    put_item(KIND_SHIFT, MASTER_ACK);
    put_item(KIND_SHIFT, 8'hFF);
    settle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin addr = 7'h7F; mask = 8'hFF; end
        1:       begin addr = 7'h00; mask = 8'h00; end   // no bit writable
        2:       begin addr = 7'h7F; mask = 8'($urandom_range(255)); end
        default: begin
          addr = 7'($urandom_range(127));
          mask = 8'($urandom_range(255));
        end
      endcase
      program_slave({1'($urandom_range(1)), addr}, mask);
      // phases 1 and 4 run with no pauses on the sending side,
      // odd phases with no stalls on the result side
      tx_gap_max   = (phase % 3 == 1) ? 0 : 3;
      rx_stall_max = (phase % 2 == 1) ? 0 : 3;
      if (phase == 0) begin
        // 255 data bytes wrap the byte count to zero: the stop is dropped
        write_xfer(addr, 8'($urandom_range(NUM_REGS - 1)), 255, 1'b1);
      end
      random_traffic(PHASE_EVENTS);
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/i2csrf_pkg.sv
rtl/i2csrf_regs.sv
rtl/i2csrf_ctrl.sv
rtl/i2c_slave_register_file.sv
sim/testbench.sv
